/* sv/wqws_pkg.sv */
// ----------------------------------------------------------------------------
// wqws_pkg
// Shared types and constants of the wait queue wake select table.
// ----------------------------------------------------------------------------
package wqws_pkg;

	localparam int WAITER_SLOTS = 128;
	localparam int TALLY_SLOTS  = 16;
	localparam int WS_W         = $clog2(WAITER_SLOTS);
	localparam int TS_W         = $clog2(TALLY_SLOTS);
	localparam int CNT_W        = WS_W + 1;

	localparam int ADDR_W  = 64;
	localparam int MASK_W  = 32;
	localparam int SLOT_W  = 7;
	localparam int WCNT_W  = 8;
	localparam int TCNT_W  = 16;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_W  = 112;
	localparam int OUT_W = 40;

	localparam logic [WCNT_W-1:0] WAKE_MAX = WCNT_W'(WAITER_SLOTS);

	// Command codes.
	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_UNREG = 2'd1;
	localparam logic [1:0] CMD_WAKE  = 2'd2;

	typedef struct packed {
		logic              granted;
		logic [MASK_W-1:0] bits;
		logic [ADDR_W-1:0] addr;
	} waiter_t;

	typedef struct packed {
		logic [MASK_W-1:0] bits;
		logic [TCNT_W-1:0] count;
		logic [ADDR_W-1:0] addr;
	} tally_t;

endpackage

/* sv/wqws_ram.sv */
// ----------------------------------------------------------------------------
// wqws_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wqws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/wait_queue_wake_select_table_unit.sv */
// ----------------------------------------------------------------------------
// wait_queue_wake_select_table_unit
// Wait table for one bucket: waiter slots, per-address tally and wake grants.
// ----------------------------------------------------------------------------
// Usage
//   Commands enter on the s_ channel, one transfer per command; each gives
//   exactly one result transfer on the m_ channel. Waiters live in a 128-entry
//   RAM, the address tally in a 16-entry RAM; occupancy and tally-live bits
//   are flip-flops, so reset takes effect at once and no clearing pass runs.
//   Steps from input transfer to result valid:
//     register   : free-slot scan, then tally scan and tally update
//     unregister : slot release, tally scan and update; none for a free slot
//     wake       : waiter RAM scan, then tally scan and lookup
//                  (no tally scan while the tally is overflowed)
//   A wake scans every slot through the single read port, so a new command
//   waits until the last one is done; one command is in work at
//   a time. s_tready is high whenever no command is in work, also while a
//   result waits in the output register. If the receiver stalls, the finished
//   command holds in its last state until the output register frees.
//   Reset (arst_n low) empties all slots and tallies and clears the cursor.
// ----------------------------------------------------------------------------
module wait_queue_wake_select_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// address[63:0], bit_mask[95:64], slot[102:96], wake_count[110:103]
	input  logic [wqws_pkg::IN_W-1:0]    s_tdata,
	// cmd[1:0]
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// slot_index[6:0], ok[7], woken[15:8], has_waiter[16], mask_match[17],
	// parked_count[33:18], grant_seen[34]
	output logic [wqws_pkg::OUT_W-1:0]   m_tdata
);
	import wqws_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_REG   = 3'd1;
	localparam logic [2:0] ST_UNREG = 3'd2;
	localparam logic [2:0] ST_WAKE  = 3'd3;
	localparam logic [2:0] ST_TSCAN = 3'd4;
	localparam logic [2:0] ST_TAPPL = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]        state_q;
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [MASK_W-1:0] mask_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WCNT_W-1:0] limit_q;
	logic [WS_W-1:0]   start_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [WAITER_SLOTS-1:0] occ_q;
	logic [TALLY_SLOTS-1:0]  live_q;
	logic [WS_W-1:0]         cursor_q;
	logic [TCNT_W-1:0]       total_q;
	logic                    ovf_q;

	// Result being built.
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_ok_q;
	logic [WCNT_W-1:0] res_woken_q;
	logic              res_has_q;
	logic              res_mm_q;
	logic [TCNT_W-1:0] res_parked_q;
	logic              res_gs_q;

	// Read pipelines of the two scans.
	logic            wv_s1;
	logic            wlast_s1;
	logic [WS_W-1:0] wix_s1;
	logic            tv_s1;
	logic [TS_W-1:0] tix_s1;

	// Tally scan findings.
	logic              hit_q;
	logic [TS_W-1:0]   hit_ix_q;
	logic [TCNT_W-1:0] hit_cnt_q;
	logic [MASK_W-1:0] hit_bits_q;
	logic              free_q;
	logic [TS_W-1:0]   free_ix_q;

	// RAM ports.
	logic            w_we;
	logic [WS_W-1:0] w_waddr;
	waiter_t         w_wdata;
	logic [WS_W-1:0] w_raddr;
	waiter_t         w_rdata;
	logic            t_we;
	logic [TS_W-1:0] t_waddr;
	tally_t          t_wdata;
	logic [TS_W-1:0] t_raddr;
	tally_t          t_rdata;

	logic              in_acc;
	logic [1:0]        in_cmd;
	logic [ADDR_W-1:0] in_addr;
	logic [MASK_W-1:0] in_mask;
	logic [SLOT_W-1:0] in_slot;
	logic [WCNT_W-1:0] in_wcnt;
	logic              w_match;
	logic              w_grant;
	logic              out_free;
	logic [TCNT_W-1:0] total_dec;

	// Input field unpacking.
	assign in_cmd  = s_tuser;
	assign in_addr = s_tdata[63:0];
	assign in_mask = s_tdata[95:64];
	assign in_slot = s_tdata[102:96];
	assign in_wcnt = s_tdata[110:103];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	wqws_ram #(.WIDTH($bits(waiter_t)), .DEPTH(WAITER_SLOTS)) u_waiter_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	wqws_ram #(.WIDTH($bits(tally_t)), .DEPTH(TALLY_SLOTS)) u_tally_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// Wake match on the slot read in the previous cycle.
	assign w_match = wv_s1 && occ_q[wix_s1] && (w_rdata.addr == addr_q);
	assign w_grant = w_match && !w_rdata.granted && ((w_rdata.bits & mask_q) != '0)
		&& (res_woken_q < limit_q);
	assign total_dec = (total_q == '0) ? '0 : total_q - 1'b1;

	// Waiter RAM access: store on register, set granted bit on wake.
	always_comb begin
		w_we    = 1'b0;
		w_waddr = wix_s1;
		w_wdata = w_rdata;
		w_wdata.granted = 1'b1;
		if (state_q == ST_REG && !occ_q[cnt_q[WS_W-1:0]]) begin
			w_we    = 1'b1;
			w_waddr = cnt_q[WS_W-1:0];
			w_wdata = '{granted: 1'b0, bits: mask_q, addr: addr_q};
		end else if (state_q == ST_WAKE && w_grant) begin
			w_we = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			w_raddr = in_slot[WS_W-1:0];
		end else begin
			w_raddr = start_q + cnt_q[WS_W-1:0];
		end
	end

	// Tally RAM access: scan reads, one write when the scan is done.
	assign t_raddr = cnt_q[TS_W-1:0];
	always_comb begin
		t_we    = 1'b0;
		t_waddr = hit_ix_q;
		t_wdata = '{bits: hit_bits_q, count: hit_cnt_q, addr: addr_q};
		if (state_q == ST_TAPPL) begin
			case (cmd_q)
				CMD_REG: begin
					if (hit_q) begin
						t_we    = 1'b1;
						t_wdata = '{bits: hit_bits_q | mask_q, count: hit_cnt_q + 1'b1,
							addr: addr_q};
					end else if (free_q) begin
						t_we    = 1'b1;
						t_waddr = free_ix_q;
						t_wdata = '{bits: mask_q, count: TCNT_W'(1), addr: addr_q};
					end
				end
				CMD_UNREG: begin
					t_we    = hit_q;
					t_wdata = '{bits: hit_bits_q, count: hit_cnt_q - 1'b1, addr: addr_q};
				end
				default: begin
					t_we = 1'b0;
				end
			endcase
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			occ_q    <= '0;
			live_q   <= '0;
			cursor_q <= '0;
			total_q  <= '0;
			ovf_q    <= 1'b0;
			wv_s1    <= 1'b0;
			tv_s1    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			wv_s1 <= 1'b0;
			tv_s1 <= 1'b0;
			// Result valid rises when the finished command moves out.
			if (state_q == ST_FIN && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						case (in_cmd)
							CMD_REG: begin
								state_q <= (in_addr == '0) ? ST_FIN : ST_REG;
							end
							CMD_UNREG: begin
								state_q <= occ_q[in_slot[WS_W-1:0]] ? ST_UNREG : ST_FIN;
							end
							CMD_WAKE: begin
								state_q <= ST_WAKE;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_REG: begin
					if (!occ_q[cnt_q[WS_W-1:0]]) begin
						occ_q[cnt_q[WS_W-1:0]] <= 1'b1;
						total_q <= total_q + 1'b1;
						cnt_q   <= '0;
						state_q <= ST_TSCAN;
					end else if (cnt_q == CNT_W'(WAITER_SLOTS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UNREG: begin
					occ_q[slot_q[WS_W-1:0]] <= 1'b0;
					total_q <= total_dec;
					if (total_dec == '0) begin
						ovf_q <= 1'b0;
					end
					state_q <= ST_TSCAN;
				end
				ST_WAKE: begin
					if (cnt_q < CNT_W'(WAITER_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						wv_s1 <= 1'b1;
					end
					if (w_grant) begin
						cursor_q <= wix_s1 + 1'b1;
					end
					if (wv_s1 && wlast_s1) begin
						cnt_q   <= '0;
						state_q <= ovf_q ? ST_FIN : ST_TSCAN;
					end
				end
				ST_TSCAN: begin
					if (cnt_q < CNT_W'(TALLY_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						tv_s1 <= 1'b1;
					end
					if (tv_s1 && tix_s1 == TS_W'(TALLY_SLOTS - 1)) begin
						state_q <= ST_TAPPL;
					end
				end
				ST_TAPPL: begin
					case (cmd_q)
						CMD_REG: begin
							if (!hit_q && free_q) begin
								live_q[free_ix_q] <= 1'b1;
							end else if (!hit_q) begin
								ovf_q <= 1'b1;
							end else if (hit_cnt_q + 1'b1 == '0) begin
								live_q[hit_ix_q] <= 1'b0;
							end
						end
						CMD_UNREG: begin
							if (hit_q && hit_cnt_q == TCNT_W'(1)) begin
								live_q[hit_ix_q] <= 1'b0;
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload, scan pipelines and result fields.
	always_ff @(posedge clk) begin
		wix_s1   <= start_q + cnt_q[WS_W-1:0];
		wlast_s1 <= (cnt_q == CNT_W'(WAITER_SLOTS - 1));
		tix_s1   <= cnt_q[TS_W-1:0];
		if (in_acc) begin
			cmd_q        <= in_cmd;
			addr_q       <= in_addr;
			mask_q       <= in_mask;
			slot_q       <= in_slot;
			limit_q      <= (in_wcnt > WAKE_MAX) ? WAKE_MAX : in_wcnt;
			start_q      <= cursor_q;
			res_slot_q   <= '0;
			res_ok_q     <= 1'b0;
			res_woken_q  <= '0;
			res_has_q    <= 1'b0;
			res_mm_q     <= 1'b0;
			res_parked_q <= '0;
			res_gs_q     <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
		end
		if (state_q == ST_REG && !occ_q[cnt_q[WS_W-1:0]]) begin
			res_slot_q <= SLOT_W'(cnt_q);
			res_ok_q   <= 1'b1;
		end
		if (state_q == ST_UNREG) begin
			res_gs_q <= w_rdata.granted;
		end
		if (state_q == ST_WAKE) begin
			if (w_match) begin
				res_has_q <= 1'b1;
			end
			if (w_grant) begin
				res_woken_q <= res_woken_q + 1'b1;
			end
			if (ovf_q) begin
				res_mm_q     <= 1'b1;
				res_parked_q <= total_q;
			end
		end
		// Tally scan: remember the live match and the first dead entry.
		if (tv_s1) begin
			if (live_q[tix_s1] && t_rdata.addr == addr_q) begin
				hit_q      <= 1'b1;
				hit_ix_q   <= tix_s1;
				hit_cnt_q  <= t_rdata.count;
				hit_bits_q <= t_rdata.bits;
			end
			if (!live_q[tix_s1] && !free_q) begin
				free_q    <= 1'b1;
				free_ix_q <= tix_s1;
			end
		end
		if (state_q == ST_TAPPL && cmd_q == CMD_WAKE && hit_q) begin
			res_mm_q     <= (hit_bits_q & mask_q) != '0;
			res_parked_q <= hit_cnt_q;
		end
		// Output register.
		if (state_q == ST_FIN && out_free) begin
			m_tdata <= {5'd0, res_gs_q, res_parked_q, res_mm_q, res_has_q,
				res_woken_q, res_ok_q, res_slot_q};
		end
	end

	// Bucket total always equals the number of occupied slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q == TCNT_W'($countones(occ_q)))
		else $error("bucket total out of step with slot occupancy");

	// Overflow can only stand while some waiter is parked.
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> total_q != '0)
		else $error("overflow set on an empty bucket");

	// A wake never grants beyond its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAKE) |-> res_woken_q <= limit_q)
		else $error("wake granted more waiters than requested");

	// The tally is written only after a full scan of it.
	assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> $past(state_q) == ST_TSCAN)
		else $error("tally write without preceding scan");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wait queue wake select table unit: commands are
// streamed in, a behavioral copy of the table predicts each result, and every
// result transfer is compared field by field under varied idle patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wqws_pkg::*;

	typedef struct packed {
		logic              grant_seen;
		logic [15:0]       parked_count;
		logic              mask_match;
		logic              has_waiter;
		logic [7:0]        woken;
		logic              ok;
		logic [6:0]        slot_index;
	} result_t;

	// Behavioral copy of the table and the queue of results it predicts.
	class wait_table_scoreboard;
		logic [63:0] w_addr [WAITER_SLOTS];
		logic [31:0] w_bits [WAITER_SLOTS];
		bit          w_grant [WAITER_SLOTS];
		int          cursor;
		logic [63:0] t_addr [TALLY_SLOTS];
		int          t_count [TALLY_SLOTS];
		logic [31:0] t_bits [TALLY_SLOTS];
		int          total;
		bit          overflow;
		result_t     pending[$];
		int          errors;

		function new();
			for (int i = 0; i < WAITER_SLOTS; i++) begin
				w_addr[i] = '0; w_bits[i] = '0; w_grant[i] = 0;
			end
			for (int i = 0; i < TALLY_SLOTS; i++) begin
				t_addr[i] = '0; t_count[i] = 0; t_bits[i] = '0;
			end
			cursor = 0; total = 0; overflow = 0; errors = 0;
		endfunction

		function int tally_lookup(logic [63:0] a);
			for (int i = 0; i < TALLY_SLOTS; i++)
				if (t_count[i] != 0 && t_addr[i] == a) return i;
			return -1;
		endfunction

		function int occupied();
			int n;
			n = 0;
			for (int i = 0; i < WAITER_SLOTS; i++) if (w_addr[i] != 0) n++;
			return n;
		endfunction

		function void note_command(logic [1:0] cmd, logic [63:0] a, logic [31:0] m,
				logic [6:0] s, logic [7:0] want);
			result_t r;
			int i, h, lim, got, idx;
			bit seen;
			r = '0;
			if (cmd == CMD_REG && a != 0) begin
				for (i = 0; i < WAITER_SLOTS; i++) if (w_addr[i] == 0) break;
				if (i < WAITER_SLOTS) begin
					w_addr[i] = a; w_bits[i] = m; w_grant[i] = 0;
					h = tally_lookup(a);
					if (h >= 0) begin
						t_count[h] = (t_count[h] + 1) & 16'hFFFF;
						t_bits[h] |= m;
					end else begin
						for (h = 0; h < TALLY_SLOTS; h++) if (t_count[h] == 0) break;
						if (h < TALLY_SLOTS) begin
							t_addr[h] = a; t_count[h] = 1; t_bits[h] = m;
						end else overflow = 1;
					end
					total = (total + 1) & 16'hFFFF;
					r.slot_index = i[6:0];
					r.ok = 1'b1;
				end
			end else if (cmd == CMD_UNREG && w_addr[s] != 0) begin
				r.grant_seen = w_grant[s];
				w_grant[s] = 0; w_bits[s] = '0; w_addr[s] = '0;
				h = tally_lookup(a);
				if (h >= 0) begin
					t_count[h]--;
					if (t_count[h] == 0) begin
						t_addr[h] = '0; t_bits[h] = '0;
					end
				end
				if (total > 0) total--;
				if (total == 0) overflow = 0;
			end else if (cmd == CMD_WAKE) begin
				lim = (want > WAKE_MAX) ? int'(WAKE_MAX) : int'(want);
				got = 0; seen = 0;
				h = cursor;
				for (int off = 0; off < WAITER_SLOTS; off++) begin
					idx = (h + off) % WAITER_SLOTS;
					if (w_addr[idx] == 0 || w_addr[idx] != a) continue;
					seen = 1;
					if (w_grant[idx] || (w_bits[idx] & m) == 0 || got >= lim) continue;
					w_grant[idx] = 1;
					cursor = (idx + 1) % WAITER_SLOTS;
					got++;
				end
				r.woken = got[7:0];
				r.has_waiter = seen;
				if (overflow) begin
					r.mask_match = 1'b1;
					r.parked_count = total[15:0];
				end else begin
					h = tally_lookup(a);
					if (h >= 0) begin
						r.mask_match = (t_bits[h] & m) != 0;
						r.parked_count = t_count[h][15:0];
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(result_t act);
			result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", act);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.slot_index !== act.slot_index) begin
				$error("slot_index exp %0d got %0d", e.slot_index, act.slot_index); errors++;
			end
			if (e.ok !== act.ok) begin
				$error("ok exp %0d got %0d", e.ok, act.ok); errors++;
			end
			if (e.woken !== act.woken) begin
				$error("woken exp %0d got %0d", e.woken, act.woken); errors++;
			end
			if (e.has_waiter !== act.has_waiter) begin
				$error("has_waiter exp %0d got %0d", e.has_waiter, act.has_waiter); errors++;
			end
			if (e.mask_match !== act.mask_match) begin
				$error("mask_match exp %0d got %0d", e.mask_match, act.mask_match); errors++;
			end
			if (e.parked_count !== act.parked_count) begin
				$error("parked_count exp %0d got %0d", e.parked_count, act.parked_count);
				errors++;
			end
			if (e.grant_seen !== act.grant_seen) begin
				$error("grant_seen exp %0d got %0d", e.grant_seen, act.grant_seen); errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// address, bit_mask, slot, wake_count, zero fill
	logic [IN_W-1:0]   s_tdata;
	// cmd
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	// slot_index, ok, woken, has_waiter, mask_match, parked_count, grant_seen
	logic [OUT_W-1:0]  m_tdata;

	wait_queue_wake_select_table_unit dut (.*);

	wait_table_scoreboard table_model = new();
	int  send_idle_pct;
	int  recv_stall_pct;
	longint cycle_count;
	bit  failed_out;

	logic [63:0] addr_pool [8];
	logic [6:0]  live_slots[$];

	// Clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Timeout counter.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2_000_000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stall, results checked on each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) table_model.check_result(result_t'(m_tdata[34:0]));
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One command, with optional idle cycles before it. Valid stays up after
	// the transfer until the next command or idle cycle replaces it.
	task automatic send_command(logic [1:0] cmd, logic [63:0] a, logic [31:0] m,
			logic [6:0] s, logic [7:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, want, s, m, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		table_model.note_command(cmd, a, m, s, want);
		if (cmd == CMD_REG && a != 0 && table_model.pending[$].ok)
			live_slots.push_back(table_model.pending[$].slot_index);
	endtask

	task automatic unregister_random();
		int k;
		logic [6:0] s;
		if (live_slots.size() == 0 || $urandom_range(9) == 0) begin
			send_command(CMD_UNREG, addr_pool[$urandom_range(7)], $urandom, 7'($urandom),
				8'($urandom));
			return;
		end
		k = $urandom_range(live_slots.size() - 1);
		s = live_slots[k];
		live_slots.delete(k);
		// Mostly the true address; sometimes a wrong one to leave the tally stale.
		send_command(CMD_UNREG,
			($urandom_range(9) != 0) ? table_model.w_addr[s] : addr_pool[$urandom_range(7)],
			$urandom, s, 8'($urandom));
	endtask

	task automatic random_command(int addr_span);
		int r;
		logic [63:0] a;
		a = ($urandom_range(19) == 0) ? {$urandom, $urandom} : addr_pool[$urandom_range(addr_span)];
		r = $urandom_range(99);
		if (r < 40)
			send_command(CMD_REG, a, ($urandom_range(3) == 0) ? $urandom : (32'h1 << $urandom_range(31)),
				7'($urandom), 8'($urandom));
		else if (r < 70)
			unregister_random();
		else if (r < 97)
			send_command(CMD_WAKE, a, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom,
				7'($urandom), ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
		else
			send_command(2'd3, {$urandom, $urandom}, $urandom, 7'($urandom), 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		addr_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		addr_pool[1] = 64'h1;
		for (int i = 2; i < 8; i++) addr_pool[i] = {$urandom, $urandom} | 64'h1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero address, wake counts, stale slots, no-op.
		send_command(CMD_REG, 64'h0, 32'hFFFF_FFFF, 7'd0, 8'd0);
		send_command(CMD_REG, addr_pool[0], 32'hFFFF_FFFF, 7'h7F, 8'hFF);
		send_command(CMD_REG, addr_pool[0], 32'h8000_0000, 7'd0, 8'd0);
		send_command(CMD_REG, addr_pool[1], 32'h0000_0001, 7'd0, 8'd0);
		send_command(CMD_WAKE, addr_pool[0], 32'h0, 7'd0, 8'd5);
		send_command(CMD_WAKE, addr_pool[0], 32'h8000_0000, 7'h7F, 8'd0);
		send_command(CMD_WAKE, addr_pool[0], 32'h8000_0000, 7'd0, 8'd1);
		send_command(CMD_WAKE, addr_pool[0], 32'hFFFF_FFFF, 7'd0, 8'hFF);
		send_command(CMD_WAKE, 64'h0, 32'hFFFF_FFFF, 7'd0, 8'd128);
		send_command(CMD_UNREG, addr_pool[0], 32'h0, 7'd0, 8'd0);
		send_command(CMD_UNREG, addr_pool[0], 32'h0, 7'd0, 8'd0);
		send_command(CMD_UNREG, 64'h0, 32'h0, 7'h7F, 8'd0);
		send_command(CMD_UNREG, addr_pool[1], 32'h0, 7'd2, 8'd0);
		send_command(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 8'hFF);
		live_slots.delete();
		for (int i = 0; i < WAITER_SLOTS; i++)
			if (table_model.w_addr[i] != 0) live_slots.push_back(i[6:0]);

		// Fill every slot with distinct addresses: tally overflow and full table.
		for (int i = 0; i < WAITER_SLOTS + 2; i++)
			send_command(CMD_REG, {$urandom, $urandom} | 64'h1, $urandom, 7'd0, 8'd0);
		send_command(CMD_WAKE, addr_pool[0], 32'h1, 7'd0, 8'd200);
		while (live_slots.size() > 0) unregister_random();
		send_command(CMD_WAKE, addr_pool[1], 32'h1, 7'd0, 8'd1);

		// Random phases with different idle patterns.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				3: begin send_idle_pct = 13; recv_stall_pct = 13; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 280; n++) random_command((ph == 4) ? 7 : 3);
		end
		s_tvalid <= 1'b0;

		while (table_model.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		failed_out = (table_model.errors != 0);
		if (!failed_out)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
